// ===== src/lcsd_pkg.sv =====
// ----------------------------------------------------------------------------
// lcsd_pkg
// Types, codes and the control program shared by the lag-correlation detector.
// ----------------------------------------------------------------------------
package lcsd_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int LAG_DEFAULT = 6;
  localparam int RATIO_W     = 16;
  localparam int THR_W       = 33;
  localparam int COUNT_W     = 16;
  localparam int Q_SHIFT     = 12;
  // energy is split into two chunks of this width for the ratio products
  localparam int CHUNK_W     = 18;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = THR_W;
  localparam logic [CFG_IDX_W-1:0] CFG_ENERGY_THR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER_RATIO = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER_RATIO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RUN_LIMIT   = 2'd3;

  localparam logic signed [RATIO_W-1:0] UPPER_RESET = 16'sd4096;
  localparam logic signed [RATIO_W-1:0] LOWER_RESET = 16'sd0;
  localparam logic [COUNT_W-1:0]        LIMIT_RESET = 16'd1;
  localparam logic [COUNT_W-1:0]        COUNT_MAX   = 16'hFFFF;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  localparam logic [1:0] VERDICT_NONE      = 2'd0;
  localparam logic [1:0] VERDICT_DETECTED  = 2'd1;
  localparam logic [1:0] VERDICT_UNDECIDED = 2'd2;

  typedef struct packed {
    logic                          opcode;
    logic signed [SAMPLE_BITS-1:0] sample;
  } req_t;

  typedef struct packed {
    logic [1:0]         verdict;
    logic [COUNT_W-1:0] run_count;
  } rsp_t;

  // multiplier operand selects
  localparam logic [1:0] A_HIST  = 2'd0;
  localparam logic [1:0] A_UPPER = 2'd1;
  localparam logic [1:0] A_LOWER = 2'd2;

  localparam logic [1:0] B_HIST = 2'd0;
  localparam logic [1:0] B_LAG  = 2'd1;
  localparam logic [1:0] B_ELO  = 2'd2;
  localparam logic [1:0] B_EHI  = 2'd3;

  // accumulator operations
  localparam logic [2:0] ACC_NONE     = 3'd0;
  localparam logic [2:0] ACC_CORR     = 3'd1;
  localparam logic [2:0] ACC_ENERGY   = 3'd2;
  localparam logic [2:0] ACC_T_LOAD   = 3'd3;
  localparam logic [2:0] ACC_T_ADD_HI = 3'd4;

  // flag captures
  localparam logic [1:0] CMP_NONE  = 2'd0;
  localparam logic [1:0] CMP_THR   = 2'd1;
  localparam logic [1:0] CMP_ABOVE = 2'd2;
  localparam logic [1:0] CMP_BELOW = 2'd3;

  localparam int UPC_W = 4;
  localparam logic [UPC_W-1:0] UPC_MAC_E     = 4'd0;
  localparam logic [UPC_W-1:0] UPC_MAC_C     = 4'd1;
  localparam logic [UPC_W-1:0] UPC_CORR_LAST = 4'd2;
  localparam logic [UPC_W-1:0] UPC_UP_LO     = 4'd3;
  localparam logic [UPC_W-1:0] UPC_UP_HI     = 4'd4;
  localparam logic [UPC_W-1:0] UPC_UP_SUM    = 4'd5;
  localparam logic [UPC_W-1:0] UPC_UP_CMP    = 4'd6;
  localparam logic [UPC_W-1:0] UPC_LO_HI     = 4'd7;
  localparam logic [UPC_W-1:0] UPC_LO_SUM    = 4'd8;
  localparam logic [UPC_W-1:0] UPC_LO_CMP    = 4'd9;
  localparam logic [UPC_W-1:0] UPC_DECIDE    = 4'd10;

  typedef struct packed {
    logic [1:0]       a_sel;
    logic [1:0]       b_sel;
    logic             mul_en;
    logic [2:0]       acc_op;
    logic [1:0]       cmp_op;
    logic             rotate;
    logic             loop;
    logic [UPC_W-1:0] target;
    logic             last;
  } uctl_t;

  // control store
  function automatic uctl_t ucode(input logic [UPC_W-1:0] upc);
    uctl_t w;
    w = '0;
    unique case (upc)
      UPC_MAC_E: begin
        w.a_sel  = A_HIST;
        w.b_sel  = B_HIST;
        w.mul_en = 1'b1;
        w.acc_op = ACC_CORR;
      end
      UPC_MAC_C: begin
        w.a_sel  = A_HIST;
        w.b_sel  = B_LAG;
        w.mul_en = 1'b1;
        w.acc_op = ACC_ENERGY;
        w.rotate = 1'b1;
        w.loop   = 1'b1;
        w.target = UPC_MAC_E;
      end
      UPC_CORR_LAST: begin
        w.acc_op = ACC_CORR;
        w.cmp_op = CMP_THR;
      end
      UPC_UP_LO: begin
        w.a_sel  = A_UPPER;
        w.b_sel  = B_ELO;
        w.mul_en = 1'b1;
      end
      UPC_UP_HI: begin
        w.a_sel  = A_UPPER;
        w.b_sel  = B_EHI;
        w.mul_en = 1'b1;
        w.acc_op = ACC_T_LOAD;
      end
      UPC_UP_SUM: begin
        w.acc_op = ACC_T_ADD_HI;
      end
      UPC_UP_CMP: begin
        w.cmp_op = CMP_ABOVE;
        w.a_sel  = A_LOWER;
        w.b_sel  = B_ELO;
        w.mul_en = 1'b1;
      end
      UPC_LO_HI: begin
        w.a_sel  = A_LOWER;
        w.b_sel  = B_EHI;
        w.mul_en = 1'b1;
        w.acc_op = ACC_T_LOAD;
      end
      UPC_LO_SUM: begin
        w.acc_op = ACC_T_ADD_HI;
      end
      UPC_LO_CMP: begin
        w.cmp_op = CMP_BELOW;
      end
      UPC_DECIDE: begin
        w.last = 1'b1;
      end
      default: begin
        w.last = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== src/lag_correlation_sd_detector.sv =====
// ----------------------------------------------------------------------------
// lag_correlation_sd_detector
// Lag-correlation signal detector run by a microcoded sequencer over a single
// shared multiplier, with a saturating run counter and a registered result.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  req      in         req_valid/req_stall  req_data  (opcode, sample)
//  rsp      out        rsp_valid/rsp_stall  rsp_data  (verdict, run_count)
//  cfg      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  a sample request runs two steps per lag tap through the one multiplier, then
//  nine steps for the threshold products and the decision; a clear runs only
//  the decision step.
//  rst is synchronous: history, run counter and registers return to defaults.
//  req_stall is high while a request is in work; a stalled result holds the
//  decision step until rsp takes it.
// ----------------------------------------------------------------------------
module lag_correlation_sd_detector
  import lcsd_pkg::*;
#(
  parameter int LAG = LAG_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  req_t                  req_data,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output rsp_t                  rsp_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int DEPTH = 2 * LAG;
  localparam int EW    = 2 * SAMPLE_BITS - 2 + $clog2(LAG + 1);
  localparam int CW    = EW + 1;
  localparam int EPW   = 2 * CHUNK_W;
  localparam int AW    = RATIO_W;
  localparam int BW    = CHUNK_W + 1;
  localparam int PW    = AW + BW;
  localparam int TW    = RATIO_W + EPW;
  localparam int XW    = (EW > THR_W) ? EW : THR_W;
  localparam int LCW   = (LAG > 1) ? $clog2(LAG) : 1;

  // configuration registers
  logic [THR_W-1:0]          energy_threshold;
  logic signed [RATIO_W-1:0] upper_ratio;
  logic signed [RATIO_W-1:0] lower_ratio;
  logic [COUNT_W-1:0]        run_limit;

  // sequencer
  logic             busy;
  logic [UPC_W-1:0] upc;
  logic [UPC_W-1:0] upc_next;
  logic [LCW-1:0]   tap;
  logic             clr;
  uctl_t            uw;
  logic             loop_taken;

  // datapath
  logic signed [SAMPLE_BITS-1:0] hist [DEPTH];
  logic signed [AW-1:0]          a_op;
  logic signed [BW-1:0]          b_op;
  logic signed [PW-1:0]          prod;
  logic [EW-1:0]                 energy;
  logic [EPW-1:0]                energy_ext;
  logic signed [CW-1:0]          corr;
  logic signed [TW-1:0]          t;
  logic signed [TW-1:0]          corr_scaled;
  logic                          low_e;
  logic                          above;
  logic                          below;

  logic [COUNT_W-1:0] run_counter;
  logic [COUNT_W-1:0] run_counter_next;
  logic [COUNT_W-1:0] count_inc;
  logic [1:0]         verdict_next;

  logic req_take;
  logic emit;

  assign cfg_ready = 1'b1;
  assign req_stall = busy;
  assign req_take  = req_valid && !busy;

  assign uw         = ucode(upc);
  assign loop_taken = uw.loop && (tap != LCW'(LAG - 1));
  assign upc_next   = loop_taken ? uw.target : upc + 1'b1;
  assign emit       = busy && uw.last && (!rsp_valid || !rsp_stall);

  assign energy_ext  = EPW'(energy);
  assign corr_scaled = TW'(corr) <<< Q_SHIFT;

  always_comb begin
    unique case (uw.a_sel)
      A_UPPER: a_op = upper_ratio;
      A_LOWER: a_op = lower_ratio;
      default: a_op = AW'(hist[0]);
    endcase
    unique case (uw.b_sel)
      B_HIST:  b_op = BW'(hist[0]);
      B_LAG:   b_op = BW'(hist[LAG]);
      B_ELO:   b_op = $signed({1'b0, energy_ext[CHUNK_W-1:0]});
      default: b_op = $signed({1'b0, energy_ext[EPW-1:CHUNK_W]});
    endcase
  end

  always_comb begin
    count_inc = (run_counter == COUNT_MAX) ? run_counter : run_counter + 1'b1;
    priority if (clr || low_e) begin
      run_counter_next = '0;
      verdict_next     = VERDICT_NONE;
    end else if (above) begin
      run_counter_next = count_inc;
      verdict_next     = (count_inc < run_limit) ? VERDICT_NONE : VERDICT_DETECTED;
    end else if (below) begin
      run_counter_next = run_counter;
      verdict_next     = VERDICT_UNDECIDED;
    end else begin
      run_counter_next = '0;
      verdict_next     = VERDICT_NONE;
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      energy_threshold <= '0;
      upper_ratio      <= UPPER_RESET;
      lower_ratio      <= LOWER_RESET;
      run_limit        <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ENERGY_THR:  energy_threshold <= cfg_data;
        CFG_UPPER_RATIO: upper_ratio      <= $signed(cfg_data[RATIO_W-1:0]);
        CFG_LOWER_RATIO: lower_ratio      <= $signed(cfg_data[RATIO_W-1:0]);
        CFG_RUN_LIMIT:   run_limit        <= cfg_data[COUNT_W-1:0];
      endcase
    end
  end

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      upc         <= UPC_MAC_E;
      tap         <= '0;
      clr         <= 1'b0;
      run_counter <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      if (emit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (req_take) begin
        busy <= 1'b1;
        tap  <= '0;
        clr  <= (req_data.opcode == OP_CLEAR);
        upc  <= (req_data.opcode == OP_CLEAR) ? UPC_DECIDE : UPC_MAC_E;
      end else if (busy) begin
        if (uw.last) begin
          if (emit) begin
            busy        <= 1'b0;
            run_counter <= run_counter_next;
          end
        end else begin
          upc <= upc_next;
          if (uw.loop) begin
            tap <= loop_taken ? tap + 1'b1 : '0;
          end
        end
      end
    end
  end

  // sample history: shift in on a sample request, zero on a clear, rotate each half during the taps
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        hist[i] <= '0;
      end
    end else if (req_take) begin
      if (req_data.opcode == OP_CLEAR) begin
        for (int i = 0; i < DEPTH; i++) begin
          hist[i] <= '0;
        end
      end else begin
        hist[0] <= req_data.sample[SAMPLE_BITS-1:0];
        for (int i = 1; i < DEPTH; i++) begin
          hist[i] <= hist[i-1];
        end
      end
    end else if (busy && uw.rotate) begin
      for (int i = 0; i < LAG - 1; i++) begin
        hist[i]       <= hist[i+1];
        hist[LAG + i] <= hist[LAG + i + 1];
      end
      hist[LAG-1]   <= hist[0];
      hist[DEPTH-1] <= hist[LAG];
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (req_take) begin
      prod   <= '0;
      energy <= '0;
      corr   <= '0;
    end else if (busy) begin
      if (uw.mul_en) begin
        prod <= PW'(a_op) * PW'(b_op);
      end
      unique case (uw.acc_op)
        ACC_CORR:     corr   <= corr + CW'(prod);
        ACC_ENERGY:   energy <= energy + EW'(prod);
        ACC_T_LOAD:   t      <= TW'(prod);
        ACC_T_ADD_HI: t      <= t + (TW'(prod) <<< CHUNK_W);
        default: ;
      endcase
      unique case (uw.cmp_op)
        CMP_THR:   low_e <= XW'(energy_threshold) > XW'(energy);
        // zero energy counts as above the upper ratio
        CMP_ABOVE: above <= (corr_scaled > t) || (energy == '0);
        CMP_BELOW: below <= corr_scaled < t;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      rsp_data.verdict   <= verdict_next;
      rsp_data.run_count <= run_counter_next;
    end
  end

  a_take_busy: assert property (@(posedge clk) disable iff (rst)
    req_take |=> busy)
    else $error("request accepted but sequencer not busy");

  a_upc_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (upc <= UPC_DECIDE))
    else $error("microcode address outside the program");

  a_detect_limit: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_data.verdict == VERDICT_DETECTED) |->
      (rsp_data.run_count >= run_limit && rsp_data.run_count != '0))
    else $error("detected reported below the run limit");

  a_verdict_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_data.verdict != 2'd3))
    else $error("illegal verdict code");

  a_clear_result: assert property (@(posedge clk) disable iff (rst)
    (emit && clr) |=> (rsp_data.run_count == '0 && run_counter == '0))
    else $error("clear left a nonzero run count");

endmodule

// ===== tb/sv/lcsd_verdict_checker.sv =====
// ----------------------------------------------------------------------------
// lcsd_verdict_checker
// Watches the request, response and register channels of the lag-correlation
// detector, keeps its own copy of the sample line, run counter and registers,
// and compares each response field by field with the oldest predicted verdict.
// ----------------------------------------------------------------------------
module lcsd_verdict_checker
  import lcsd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  input  logic                  req_stall,
  input  req_t                  req_data,
  input  logic                  rsp_valid,
  input  logic                  rsp_stall,
  input  rsp_t                  rsp_data,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    outstanding,
  output int                    checked
);

  localparam int TAPS  = LAG_DEFAULT;
  localparam int DEPTH = 2 * TAPS;

  logic signed [SAMPLE_BITS-1:0] line_hist [DEPTH];
  logic [COUNT_W-1:0]            run_cnt;
  logic [THR_W-1:0]              energy_thr;
  logic signed [RATIO_W-1:0]     upper_thr;
  logic signed [RATIO_W-1:0]     lower_thr;
  logic [COUNT_W-1:0]            detect_limit;

  rsp_t verdict_queue [$];
  int   mismatch_cnt = 0;
  int   pending_cnt  = 0;
  int   checked_cnt  = 0;

  assign mismatches  = mismatch_cnt;
  assign outstanding = pending_cnt;
  assign checked     = checked_cnt;

  task automatic report_mismatch(input string msg);
    $display("mismatch on result %0d: %s", checked_cnt, msg);
    mismatch_cnt++;
  endtask

  // shift one sample request through the line (a clear empties it) and queue the verdict it should give
  task automatic advance_detector(input req_t r);
    longint energy;
    longint corr;
    logic   above;
    logic   below;
    rsp_t   want;
    energy = 0;
    corr   = 0;
    above  = 1'b0;
    below  = 1'b0;
    if (r.opcode == OP_CLEAR) begin
      foreach (line_hist[i]) line_hist[i] = '0;
      run_cnt = '0;
      want.verdict   = VERDICT_NONE;
      want.run_count = '0;
    end else begin
      for (int i = DEPTH - 1; i > 0; i--) line_hist[i] = line_hist[i-1];
      line_hist[0] = r.sample;
      for (int i = 0; i < TAPS; i++) begin
        energy += longint'(line_hist[i]) * longint'(line_hist[i]);
        corr   += longint'(line_hist[i]) * longint'(line_hist[i+TAPS]);
      end
      if (longint'(energy_thr) > energy) begin
        run_cnt      = '0;
        want.verdict = VERDICT_NONE;
      end else begin
        // ratio compared exactly by cross-multiplying, silent line counts as above
        if (energy == 0) begin
          above = 1'b1;
        end else begin
          above = (corr * 4096) > (longint'(upper_thr) * energy);
          below = (corr * 4096) < (longint'(lower_thr) * energy);
        end
        if (above) begin
          if (run_cnt != COUNT_MAX) run_cnt++;
          want.verdict = (run_cnt < detect_limit) ? VERDICT_NONE : VERDICT_DETECTED;
        end else if (below) begin
          want.verdict = VERDICT_UNDECIDED;
        end else begin
          run_cnt      = '0;
          want.verdict = VERDICT_NONE;
        end
      end
      want.run_count = run_cnt;
    end
    verdict_queue.push_back(want);
  endtask

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      foreach (line_hist[i]) line_hist[i] = '0;
      run_cnt      = '0;
      energy_thr   = '0;
      upper_thr    = UPPER_RESET;
      lower_thr    = LOWER_RESET;
      detect_limit = LIMIT_RESET;
      verdict_queue.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ENERGY_THR:  energy_thr   = cfg_data[THR_W-1:0];
          CFG_UPPER_RATIO: upper_thr    = cfg_data[RATIO_W-1:0];
          CFG_LOWER_RATIO: lower_thr    = cfg_data[RATIO_W-1:0];
          CFG_RUN_LIMIT:   detect_limit = cfg_data[COUNT_W-1:0];
          default: ;
        endcase
      end
      if (rsp_valid && !rsp_stall) begin
        if (verdict_queue.size() == 0) begin
          report_mismatch($sformatf("result with no request waiting: verdict %0d run_count %0d",
                                    rsp_data.verdict, rsp_data.run_count));
        end else begin
          want = verdict_queue.pop_front();
          if (rsp_data.verdict !== want.verdict) begin
            report_mismatch($sformatf("verdict %0d, expected %0d",
                                      rsp_data.verdict, want.verdict));
          end
          if (rsp_data.run_count !== want.run_count) begin
            report_mismatch($sformatf("run_count %0d, expected %0d",
                                      rsp_data.run_count, want.run_count));
          end
        end
        checked_cnt++;
      end
      if (req_valid && !req_stall) begin
        advance_detector(req_data);
      end
    end
    pending_cnt = verdict_queue.size();
  end

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Drives the lag-correlation detector with directed edge cases, patterned and
// noisy random sample streams under several register settings, and a run of
// silence that keeps the run counter climbing, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb;
  import lcsd_pkg::*;

  localparam int CYCLE_LIMIT   = 3000000;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 140;
  localparam int SETTLE_CYCLES = 30;
  localparam int QUIET_ITEMS   = 40;

  typedef enum int {PAT_REPEAT, PAT_FLIP, PAT_NOISE, PAT_QUIET} pattern_e;

  logic                  clk;
  logic                  rst;
  logic                  req_valid;
  logic                  req_stall;
  req_t                  req_data;
  logic                  rsp_valid;
  logic                  rsp_stall;
  rsp_t                  rsp_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int mismatches;
  int outstanding;
  int checked;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int cycles        = 0;
  int req_cnt       = 0;
  int clear_cnt     = 0;
  int setting_cnt   = 0;

  lag_correlation_sd_detector DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  lcsd_verdict_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req_data    (req_data),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .rsp_data    (rsp_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .checked     (checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(negedge clk) begin
    rsp_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  function automatic logic signed [SAMPLE_BITS-1:0] rand_sample(input int shift);
    logic signed [SAMPLE_BITS-1:0] v;
    v = SAMPLE_BITS'($urandom);
    return v >>> shift;
  endfunction

  // log-uniform spread so thresholds land near real six-sample energies
  function automatic logic [THR_W-1:0] rand_threshold();
    logic [THR_W-1:0] v;
    v[31:0] = $urandom;
    v[32]   = 1'($urandom_range(0, 1));
    return v >> $urandom_range(0, THR_W - 1);
  endfunction

  task automatic send_request(input req_t r);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    req_cnt++;
    if (r.opcode == OP_CLEAR) clear_cnt++;
  endtask

  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] s);
    req_t r;
    r.opcode = OP_SAMPLE;
    r.sample = s;
    send_request(r);
  endtask

  task automatic send_clear(input logic signed [SAMPLE_BITS-1:0] junk);
    req_t r;
    r.opcode = OP_CLEAR;
    r.sample = junk;
    send_request(r);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    req_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_setting(input logic [THR_W-1:0] thr,
                               input logic signed [RATIO_W-1:0] upper,
                               input logic signed [RATIO_W-1:0] lower,
                               input logic [COUNT_W-1:0] limit);
    write_reg(CFG_ENERGY_THR, thr);
    write_reg(CFG_UPPER_RATIO, {{(CFG_DATA_W-RATIO_W){1'b0}}, upper});
    write_reg(CFG_LOWER_RATIO, {{(CFG_DATA_W-RATIO_W){1'b0}}, lower});
    write_reg(CFG_RUN_LIMIT, {{(CFG_DATA_W-COUNT_W){1'b0}}, limit});
    setting_cnt++;
  endtask

  initial begin
    logic signed [SAMPLE_BITS-1:0] motif [6];
    pattern_e pat;
    int       left;
    int       burst;
    int       shift;
    req_t     r;

    rst       = 1'b1;
    req_valid = 1'b0;
    req_data  = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_ENERGY_THR;
    cfg_data  = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part on the reset register values
    send_idle_pct = 37;
    stall_pct     = 48;
    send_clear(16'sh7FFF);
    send_sample(16'sd0);
    motif = '{16'sh7FFF, 16'sh8000, 16'sd1, -16'sd1, 16'sd12345, -16'sd20000};
    // second period gives a ratio of exactly one
    for (int k = 0; k < 12; k++) send_sample(motif[k % 6]);
    // sign flip against the lag on the last four samples only; the first two keep the lag's sign
    send_sample(16'sh7FFF);
    send_sample(-16'sh7FFF);
    send_sample(-16'sd1);
    send_sample(16'sd1);
    send_sample(-16'sd12345);
    send_sample(16'sd20000);
    send_clear(16'sh8000);
    send_sample(16'sd0);
    send_sample(16'sd0);
    wait_idle();

    for (int p = 0; p < PHASES; p++) begin
      send_idle_pct = (p < 3) ? 37 : (p < 6) ? 48 : 0;
      stall_pct     = (p < 3) ? 48 : (p < 6) ? 37 : 0;
      case (p)
        0: apply_setting('0, 16'sd4096, 16'sd0, 16'd2);
        1: apply_setting({THR_W{1'b1}}, 16'sh7FFF, 16'sh8000, COUNT_MAX);
        2: apply_setting(rand_threshold(), 16'sh8000, 16'sh8000, 16'd0);
        3: apply_setting(rand_threshold(), 16'sh7FFF, 16'sh7FFF, 16'd1);
        4: apply_setting('0, 16'sd3000, -16'sd3000, 16'd4);
        default: apply_setting(rand_threshold(), rand_sample(0), rand_sample(0),
                               16'($urandom_range(0, 8)));
      endcase
      left = PHASE_ITEMS;
      while (left > 0) begin
        pat   = pattern_e'($urandom_range(0, 3));
        burst = $urandom_range(6, 36);
        shift = $urandom_range(0, 15);
        foreach (motif[i]) motif[i] = rand_sample(shift);
        for (int k = 0; k < burst && left > 0; k++) begin
          r.opcode = OP_SAMPLE;
          case (pat)
            PAT_REPEAT: r.sample = ($urandom_range(0, 9) == 0) ? rand_sample(shift)
                                                               : motif[k % 6];
            PAT_FLIP:   r.sample = ((k / 6) % 2) ? -motif[k % 6] : motif[k % 6];
            PAT_NOISE:  r.sample = ($urandom_range(0, 7) == 0) ? '0 : rand_sample(0);
            default:    r.sample = rand_sample(shift);
          endcase
          if ($urandom_range(0, 99) < 3) begin
            r.opcode = OP_CLEAR;
            r.sample = rand_sample(0);
          end
          send_request(r);
          left--;
        end
      end
      wait_idle();
    end

    // silent line counts as above every time: the run counter climbs past the limit
    apply_setting('0, 16'sd0, 16'sd0, 16'd30);
    send_clear(16'sd0);
    for (int k = 0; k < QUIET_ITEMS; k++) send_sample(16'sd0);
    wait_idle();

    $display("%0d requests (%0d clears) under %0d register settings, %0d results checked",
             req_cnt, clear_cnt, setting_cnt, checked);
    $display("ends with a run of %0d silent samples climbing through the run limit",
             QUIET_ITEMS);
    if (mismatches == 0 && outstanding == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
